### hdl/lpt_code_child_neighbor_unit_top_macros.svh
// Assertion helpers shared by the unit
`ifndef LPT_CODE_CHILD_NEIGHBOR_UNIT_TOP_MACROS_SVH
`define LPT_CODE_CHILD_NEIGHBOR_UNIT_TOP_MACROS_SVH

// overlapping implication, reset masks the check
`define LCN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcn assertion failed");

// non-overlapping implication
`define LCN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcn assertion failed");

`endif

### hdl/lcn_pkg.sv
package lcn_pkg;

   localparam int MaxOrthants = 16;
   // the 32-bit list holds sixteen orthants at most
   localparam int OrthCap     = (MaxOrthants < 16) ? MaxOrthants : 16;
   localparam int ListW       = 32;
   localparam int NumOrth     = ListW / 2;

   // deepest level a code may carry, and the level from which a child is too deep
   localparam logic [5:0] LevMax = 6'(2 * OrthCap + 1);

   localparam logic [2:0] ReqChild0 = 3'd0;
   localparam logic [2:0] ReqChild1 = 3'd1;
   localparam logic [2:0] ReqNeigh0 = 3'd2;
   localparam logic [2:0] ReqNeigh1 = 3'd3;
   localparam logic [2:0] ReqNeigh2 = 3'd4;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StDepth   = 2'd1;
   localparam logic [1:0] StOutside = 2'd2;
   localparam logic [1:0] StUnused  = 2'd3;

   typedef enum logic [2:0] {
      ShapeEcho,
      ShapeChild,
      ShapeFlip,
      ShapeKeep,
      ShapeReplace
   } shape_type;

   typedef struct packed {
      logic             valid;
      logic [2:0]       req;
      logic [5:0]       lev;
      logic [2:0]       perm;
      logic [ListW-1:0] list;
      logic             kind;
      logic             over;
   } dec_type;

   typedef struct packed {
      logic             valid;
      shape_type        shape;
      logic [1:0]       status;
      logic [5:0]       lev;
      logic [2:0]       perm;
      logic [2:0]       new_perm;
      logic [ListW-1:0] list;
      logic [ListW-1:0] flips;
      logic             kind;
   } walk_type;

   // orthant implied by a signed permutation: x sign low, y sign high
   function automatic logic [1:0] orthant_of(input logic [2:0] p);
      logic [1:0] o;
      if (p[0]) begin
         o = {p[1], p[2]};
      end else begin
         o = {p[2], p[1]};
      end
      return o;
   endfunction

endpackage

### hdl/lcn_decode.sv
module lcn_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2:0]              req_type,
   input  logic [5:0]              req_level,
   input  logic [2:0]              req_perm_bits,
   input  logic [31:0]             req_orthant_list,
   output lcn_pkg::dec_type        dec_out
);
   import lcn_pkg::*;

   dec_type          dec_in;
   dec_type          dec_ff;
   logic [4:0]       n;
   logic [4:0]       n_keep;
   logic             over;
   logic [ListW-1:0] keep;
   logic [ListW-1:0] list;
   logic             lm;
   logic             sign;
   logic             axis;
   logic             last;
   logic [3:0]       nm1;
   logic             kind;

   always_comb begin
      n      = req_level[5:1];
      over   = req_level > LevMax;
      n_keep = over ? 5'(OrthCap) : n;
      for (int i = 0; i < NumOrth; i++) begin
         keep[2*i +: 2] = (5'(i) < n_keep) ? 2'b11 : 2'b00;
      end
      list = req_orthant_list & keep;

      // child kind from the last orthant against the moving sign
      lm   = ~req_level[0];
      sign = lm ? req_perm_bits[2] : req_perm_bits[1];
      axis = (lm == req_perm_bits[0]) ? 1'b0 : 1'b1;
      nm1  = 4'(n - 5'd1);
      last = (req_level <= 6'd2) ? 1'b0 : list[{nm1, axis}];
      if (over) begin
         kind = 1'b0;
      end else if (n == 5'd0) begin
         kind = req_perm_bits[1];
      end else begin
         kind = sign ^ last;
      end

      dec_in.valid = in_valid;
      dec_in.req   = req_type;
      dec_in.lev   = req_level;
      dec_in.perm  = req_perm_bits;
      dec_in.list  = list;
      dec_in.kind  = kind;
      dec_in.over  = over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= '0;
      end else begin
         dec_ff <= dec_in;
      end
   end

   assign dec_out = dec_ff;

endmodule

### hdl/lcn_walk.sv
module lcn_walk (
   input  logic              clock,
   input  logic              reset,
   input  lcn_pkg::dec_type  dec_in_w,
   output lcn_pkg::walk_type walk_out
);
   import lcn_pkg::*;

   walk_type         walk_in;
   walk_type         walk_ff;
   logic             b0;
   logic             b1;
   logic             b2;
   logic [4:0]       n;
   logic [NumOrth-1:0] rng;
   logic [NumOrth-1:0] miss;
   logic [NumOrth-1:0] covered;
   logic [ListW-1:0] flips;
   logic             found;
   logic             ls_hit;
   shape_type        shape;
   logic [1:0]       status;
   logic [2:0]       np;

   always_comb begin
      b0 = dec_in_w.perm[0];
      b1 = dec_in_w.perm[1];
      b2 = dec_in_w.perm[2];
      n  = dec_in_w.lev[5:1];

      // ancestor walk: highest orthant whose axis bit differs from the sign stops it
      for (int i = 0; i < NumOrth; i++) begin
         rng[i]  = 5'(i) < n;
         miss[i] = rng[i] & ((b0 ? dec_in_w.list[2*i+1] : dec_in_w.list[2*i]) ^ b1);
      end
      for (int i = 0; i < NumOrth; i++) begin
         covered[i]     = rng[i] & ((miss >> (i + 1)) == '0);
         flips[2*i]     = covered[i] & ~b0;
         flips[2*i + 1] = covered[i] & b0;
      end
      found = |miss;

      ls_hit = dec_in_w.kind &&
               ((dec_in_w.req == ReqNeigh1 && dec_in_w.lev[0]) ||
                (dec_in_w.req == ReqNeigh2 && !dec_in_w.lev[0]));

      shape  = ShapeEcho;
      status = StOk;
      np     = dec_in_w.perm;
      priority if (dec_in_w.over) begin
         status = StDepth;
      end else if (dec_in_w.req == ReqChild0 || dec_in_w.req == ReqChild1) begin
         if (dec_in_w.lev >= LevMax) begin
            status = StDepth;
         end else begin
            shape = ShapeChild;
            if (dec_in_w.req == ReqChild1) begin
               np = dec_in_w.lev[0] ? {~b2, b1, b0} : {b1, ~b2, ~b0};
            end
         end
      end else if (dec_in_w.req == ReqNeigh0) begin
         np = {b2, ~b1, b0};
         if (found) begin
            shape = ShapeFlip;
         end else begin
            status = StOutside;
         end
      end else if (ls_hit) begin
         np = dec_in_w.lev[0] ? {~b1, b2, ~b0} : {~b2, b1, b0};
         shape = (dec_in_w.req == ReqNeigh2 && n != 5'd0) ? ShapeReplace : ShapeKeep;
      end else if (dec_in_w.req == ReqNeigh1) begin
         np    = {b1, b2, ~b0};
         shape = ShapeKeep;
      end else begin
         status = StUnused;
      end

      walk_in.valid    = dec_in_w.valid;
      walk_in.shape    = shape;
      walk_in.status   = status;
      walk_in.lev      = dec_in_w.lev;
      walk_in.perm     = dec_in_w.perm;
      walk_in.new_perm = np;
      walk_in.list     = dec_in_w.list;
      walk_in.flips    = flips;
      walk_in.kind     = dec_in_w.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= '0;
      end else begin
         walk_ff <= walk_in;
      end
   end

   assign walk_out = walk_ff;

endmodule

### hdl/lcn_assemble.sv
module lcn_assemble (
   input  logic              clock,
   input  logic              reset,
   input  lcn_pkg::walk_type walk_in_a,
   output logic              rsp_strobe,
   output logic [5:0]        rsp_out_level,
   output logic [2:0]        rsp_out_perm_bits,
   output logic [31:0]       rsp_out_orthant_list,
   output logic              rsp_child_kind,
   output logic [1:0]        rsp_status
);
   import lcn_pkg::*;

   logic             strobe_ff;
   logic [5:0]       level_in;
   logic [5:0]       level_ff;
   logic [2:0]       perm_in;
   logic [2:0]       perm_ff;
   logic [ListW-1:0] list_in;
   logic [ListW-1:0] list_ff;
   logic             kind_ff;
   logic [1:0]       status_ff;
   logic [3:0]       n4;
   logic [3:0]       nm1;

   always_comb begin
      n4       = walk_in_a.lev[4:1];
      nm1      = 4'(walk_in_a.lev[5:1] - 5'd1);
      level_in = walk_in_a.lev;
      perm_in  = walk_in_a.new_perm;
      list_in  = walk_in_a.list;
      unique case (walk_in_a.shape)
         ShapeEcho: begin
            perm_in = walk_in_a.perm;
         end
         ShapeChild: begin
            level_in = walk_in_a.lev + 6'd1;
            // new level even: append the orthant of the new permutation
            if (walk_in_a.lev[0]) begin
               list_in[{n4, 1'b0} +: 2] = orthant_of(walk_in_a.new_perm);
            end
         end
         ShapeFlip: begin
            list_in = walk_in_a.list ^ walk_in_a.flips;
         end
         ShapeKeep: begin
         end
         ShapeReplace: begin
            list_in[{nm1, 1'b0} +: 2] = orthant_of(walk_in_a.perm);
         end
         default: begin
            perm_in = walk_in_a.perm;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= walk_in_a.valid;
      end
      level_ff  <= level_in;
      perm_ff   <= perm_in;
      list_ff   <= list_in;
      kind_ff   <= walk_in_a.kind;
      status_ff <= walk_in_a.status;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_out_level        = level_ff;
   assign rsp_out_perm_bits    = perm_ff;
   assign rsp_out_orthant_list = list_ff;
   assign rsp_child_kind       = kind_ff;
   assign rsp_status           = status_ff;

endmodule

### hdl/lpt_code_child_neighbor_unit_top.sv
// An accepted word is registered in decode, then in the ancestor walk, then in
// assembly, which drives the result strobe; these are three register stages.
// Throughput: one word every cycle while not busy; the pipeline never holds
// start off. Reset: synchronous, active high; clears the stage valid bits, busy
// is high only while reset is asserted. The receiver cannot stall the result.
`include "lpt_code_child_neighbor_unit_top_macros.svh"

module lpt_code_child_neighbor_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_level,
   input  logic [2:0]  req_perm_bits,
   input  logic [31:0] req_orthant_list,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_out_level,
   output logic [2:0]  rsp_out_perm_bits,
   output logic [31:0] rsp_out_orthant_list,
   output logic        rsp_child_kind,
   output logic [1:0]  rsp_status
);
   import lcn_pkg::*;

   logic     accept;
   dec_type  dec;
   walk_type walk;

   assign busy   = reset;
   assign accept = start & ~busy;

   lcn_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .req_type         (req_type),
      .req_level        (req_level),
      .req_perm_bits    (req_perm_bits),
      .req_orthant_list (req_orthant_list),
      .dec_out          (dec)
   );

   lcn_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .dec_in_w (dec),
      .walk_out (walk)
   );

   lcn_assemble u_assemble (
      .clock                (clock),
      .reset                (reset),
      .walk_in_a            (walk),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_level        (rsp_out_level),
      .rsp_out_perm_bits    (rsp_out_perm_bits),
      .rsp_out_orthant_list (rsp_out_orthant_list),
      .rsp_child_kind       (rsp_child_kind),
      .rsp_status           (rsp_status)
   );

   // every accepted word comes out of the assembly register as a result strobe
   `LCN_ASSERT_IMPL(a_latency, clock, reset, accept, 1'b1 ##3 rsp_strobe)
   `LCN_ASSERT_IMPL(a_no_stray, clock, reset, rsp_strobe, $past(accept, 3))
   // a refused request echoes the level it was given
   `LCN_ASSERT_IMPL(a_echo_level, clock, reset, rsp_strobe && rsp_status != StOk,
      rsp_out_level == $past(req_level, 3))
   // a good result keeps the level or goes one deeper
   `LCN_ASSERT_IMPL(a_level_step, clock, reset, rsp_strobe && rsp_status == StOk,
      rsp_out_level == $past(req_level, 3) ||
      rsp_out_level == $past(req_level, 3) + 6'd1)

endmodule
